>>> design/smeu_pkg.sv
// ----------------------------------------------------------------------------
// smeu_pkg
// Shared types and constants of the stack machine execute unit.
// ----------------------------------------------------------------------------
package smeu_pkg;

	localparam int STACK_DEPTH      = 64;
	localparam int LOCALS_PER_FRAME = 16;
	localparam int PC_BITS          = 16;
	localparam int SP_W  = $clog2(STACK_DEPTH + 1);
	localparam int SA_W  = $clog2(STACK_DEPTH);
	localparam int LA_W  = $clog2(LOCALS_PER_FRAME) > 0 ? $clog2(LOCALS_PER_FRAME) : 1;
	localparam int LM_W  = $clog2(STACK_DEPTH * LOCALS_PER_FRAME);
	localparam int DIV_CNT_W = 7;

	typedef enum logic [3:0] {
		OP_PUSH = 4'd0, OP_POP = 4'd1, OP_SWAP = 4'd2, OP_LOAD = 4'd3,
		OP_STORE = 4'd4, OP_EXIT = 4'd5, OP_CALL = 4'd6, OP_RET = 4'd7,
		OP_ADD = 4'd8, OP_SUB = 4'd9, OP_MUL = 4'd10, OP_DIV = 4'd11
	} op_t;

	localparam logic [1:0] HS_RUN = 2'd0, HS_EXIT = 2'd1, HS_END = 2'd2, HS_ERR = 2'd3;

	localparam logic [2:0] ER_NONE = 3'd0, ER_SOVF = 3'd1, ER_SUNF = 3'd2, ER_LIDX = 3'd3,
		ER_FOVF = 3'd4, ER_FUNF = 3'd5, ER_DIVZ = 3'd6, ER_BAD = 3'd7;

	localparam logic [1:0] CFG_PLEN = 2'd0, CFG_SLIM = 2'd1, CFG_NLOC = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_MUL, ST_WB, ST_OUT
	} state_t;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] q;
	} div_rsp_t;

endpackage

>>> design/smeu_div.sv
// ----------------------------------------------------------------------------
// smeu_div
// Radix-2 restoring signed divider, truncating, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module smeu_div (
	input  logic               clk,
	input  logic               arst_n,
	input  smeu_pkg::div_req_t req,
	output smeu_pkg::div_rsp_t rsp
);
	import smeu_pkg::*;

	logic [63:0] rem_q, quo_q, dvs_q;
	logic        neg_q, busy_q, done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [64:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(64);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.a[63] ? 64'(0 - req.a) : req.a;
			dvs_q <= req.b[63] ? 64'(0 - req.b) : req.b;
			neg_q <= req.a[63] ^ req.b[63];
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.q    = neg_q ? 64'(0 - quo_q) : quo_q;

endmodule

>>> design/stack_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// Executes one stack-machine instruction per item and reports pc and status.
// ----------------------------------------------------------------------------
// Most opcodes pass through four states after acceptance: read of the operand
// stack memory (two ports, registered), execute, write-back and output. The
// result item is offered in the output state; the next item is taken only
// once that result has been taken and the block is back in idle. Multiply
// adds a multiply state: one 32x32 multiplier forms the low, cross and cross
// partial products in turn. Divide adds a divide state that waits for the
// divider (one quotient bit a cycle, 64 bits) to raise done. Input
// stall is high from acceptance until the result item has been taken. Locals
// live in a 1024-entry memory; a local read before it is written in its frame
// is unspecified. There is no clearing pass.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  action,
	input  logic signed [63:0] operand,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] next_pc,
	output logic        halted,
	output logic [1:0]  stop_cause,
	output logic [2:0]  error_code,
	output logic signed [63:0] top_value,
	output logic [6:0]  stack_depth,
	output logic [6:0]  frame_depth
);
	import smeu_pkg::*;

	// configuration
	logic [16:0] plen_q;
	logic [6:0]  slim_q;
	logic [4:0]  nloc_q;

	// architectural state
	logic [PC_BITS-1:0] pc_q;
	logic [SP_W-1:0]    sp_q, fc_q;
	logic [1:0]         hs_q;
	logic [2:0]         err_q;
	logic [63:0]        top_q;

	// item
	logic [3:0]  act_q;
	logic [63:0] opd_q;
	state_t      st_q, st_d;

	logic [63:0] stk_mem [STACK_DEPTH];
	logic [63:0] loc_mem [STACK_DEPTH * LOCALS_PER_FRAME];
	logic [63:0] rd_a_q, rd_b_q, loc_rd_q, res_q;

	// writeback plan, built in EXEC
	logic        wa_en_q, wb_en_q, lw_en_q;
	logic        e_ok;
	logic [SA_W-1:0] wa_addr_q, wb_addr_q;
	logic [63:0] wa_data_q, wb_data_q;
	logic [LM_W-1:0] lw_addr_q;
	logic [SP_W-1:0] sp_new_q, fc_new_q;
	logic [32:0] next_q;
	logic [2:0]  perr_q;
	logic        pexit_q;

	// multiply sequencer: partial product step
	logic [1:0]  mcnt_q;
	logic [31:0] mop_a, mop_b;
	logic [63:0] mprod, mul_sum;

	div_req_t dreq;
	div_rsp_t drsp;

	smeu_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// limits
	logic [SP_W-1:0] cap;
	logic [LA_W:0]   nl;
	assign cap = (slim_q < 7'(STACK_DEPTH)) ? SP_W'(slim_q) : SP_W'(STACK_DEPTH);
	assign nl  = (nloc_q < 5'(LOCALS_PER_FRAME)) ? (LA_W+1)'(nloc_q)
	                                             : (LA_W+1)'(LOCALS_PER_FRAME);

	assign cfg_ready = (st_q == ST_IDLE);
	assign in_stall  = (st_q != ST_IDLE);
	assign out_valid = (st_q == ST_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= '0;
			slim_q <= 7'd64;
			nloc_q <= 5'd16;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PLEN: plen_q <= cfg_data;
				CFG_SLIM: slim_q <= cfg_data[6:0];
				CFG_NLOC: nloc_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else         st_q <= st_d;
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (in_valid) st_d = ST_READ;
			ST_READ: st_d = ST_EXEC;
			ST_EXEC: begin
				if (e_ok && act_q == OP_DIV && pexit_q) st_d = ST_DIV;
				else if (e_ok && act_q == OP_MUL && pexit_q) st_d = ST_MUL;
				else st_d = ST_WB;
			end
			ST_DIV: if (drsp.done) st_d = ST_WB;
			ST_MUL: if (mcnt_q == 2'd2) st_d = ST_WB;
			ST_WB:  st_d = ST_OUT;
			ST_OUT: if (!out_stall) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// stack reads: top-1 or swap partner on port A, top on port B
	logic [SP_W-1:0] rd_a_idx;
	logic [SA_W-1:0] fbase_frame;
	logic [LM_W-1:0] lrd_addr;
	assign rd_a_idx = (act_q == OP_SWAP) ? SP_W'(sp_q - 1'b1 - SP_W'(opd_q[SP_W-1:0]))
	                                     : SP_W'(sp_q - 2'd2);
	assign fbase_frame = SA_W'(fc_q - 1'b1);
	assign lrd_addr = {fbase_frame, LA_W'(opd_q[LA_W-1:0])};

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && in_valid) begin
			act_q <= action;
			opd_q <= operand;
		end
		if (st_q == ST_READ) begin
			rd_a_q   <= stk_mem[rd_a_idx[SA_W-1:0]];
			rd_b_q   <= stk_mem[SA_W'(sp_q - 1'b1)];
			loc_rd_q <= loc_mem[lrd_addr];
		end
		if (wa_en_q && st_q == ST_WB) stk_mem[wa_addr_q] <= wa_data_q;
		if (wb_en_q && st_q == ST_WB) stk_mem[wb_addr_q] <= wb_data_q;
		if (lw_en_q && st_q == ST_WB) loc_mem[lw_addr_q] <= rd_b_q;
	end

	// execute decode (combinational, registered into plan)
	logic [2:0]  e_err;
	logic        e_wa, e_wb, e_lw, e_exit;
	logic [SA_W-1:0] e_waa, e_wba;
	logic [63:0] e_wad, e_wbd;
	logic [SP_W-1:0] e_sp, e_fc;
	logic [32:0] e_next;
	logic        opd_big_sp, opd_big_loc;

	assign opd_big_sp  = (opd_q >= 64'(sp_q));
	assign opd_big_loc = (opd_q >= 64'(nl));

	always_comb begin
		e_err = ER_NONE; e_wa = 1'b0; e_wb = 1'b0; e_lw = 1'b0; e_exit = 1'b0;
		e_waa = SA_W'(sp_q); e_wba = SA_W'(sp_q - 1'b1);
		e_wad = opd_q; e_wbd = rd_a_q;
		e_sp = sp_q; e_fc = fc_q;
		e_next = 33'(pc_q) + 33'd1;
		case (act_q)
			OP_PUSH: if (sp_q >= cap) e_err = ER_SOVF;
				else begin e_wa = 1'b1; e_sp = sp_q + 1'b1; end
			OP_POP: if (sp_q == '0) e_err = ER_SUNF; else e_sp = sp_q - 1'b1;
			OP_SWAP: if (opd_big_sp) e_err = ER_BAD;
				else begin
					e_wa = 1'b1; e_waa = rd_a_idx[SA_W-1:0]; e_wad = rd_b_q;
					e_wb = 1'b1;
				end
			OP_LOAD: if (opd_big_loc) e_err = ER_LIDX;
				else if (sp_q >= cap) e_err = ER_SOVF;
				else begin e_wa = 1'b1; e_wad = loc_rd_q; e_sp = sp_q + 1'b1; end
			OP_STORE: if (sp_q == '0) e_err = ER_SUNF;
				else if (opd_big_loc) e_err = ER_LIDX;
				else begin e_lw = 1'b1; e_sp = sp_q - 1'b1; end
			OP_EXIT: e_exit = 1'b1;
			OP_CALL: if (fc_q >= cap) e_err = ER_FOVF;
				else if (sp_q >= cap) e_err = ER_SOVF;
				else begin
					e_wa = 1'b1; e_wad = 64'(pc_q) + 64'd1; e_fc = fc_q + 1'b1;
					e_sp = sp_q + 1'b1;
					e_next = {|opd_q[63:32], opd_q[31:0]};
				end
			OP_RET: if (fc_q <= SP_W'(1)) e_err = ER_FUNF;
				else if (sp_q == '0) e_err = ER_SUNF;
				else begin
					e_fc = fc_q - 1'b1; e_sp = sp_q - 1'b1;
					e_next = {|rd_b_q[63:32], rd_b_q[31:0]};
				end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV:
				if (sp_q < SP_W'(2)) e_err = ER_SUNF;
				else if (act_q == OP_DIV && rd_b_q == '0) e_err = ER_DIVZ;
				else begin
					e_wa = 1'b1; e_waa = SA_W'(sp_q - 2'd2);
					e_wad = (act_q == OP_ADD) ? rd_a_q + rd_b_q : rd_a_q - rd_b_q;
					e_sp = sp_q - 1'b1;
				end
			default: e_err = ER_BAD;
		endcase
	end

	assign e_ok = (e_err == ER_NONE) && !e_exit;

	// low 64 bits of a*b: lo*lo, then lo(a)*hi(b) and hi(a)*lo(b) shifted up
	always_comb begin
		case (mcnt_q)
			2'd0: begin mop_a = rd_a_q[31:0];  mop_b = rd_b_q[31:0];  end
			2'd1: begin mop_a = rd_a_q[31:0];  mop_b = rd_b_q[63:32]; end
			default: begin mop_a = rd_a_q[63:32]; mop_b = rd_b_q[31:0]; end
		endcase
	end
	assign mprod   = {32'd0, mop_a} * {32'd0, mop_b};
	assign mul_sum = (mcnt_q == 2'd0) ? mprod : res_q + {mprod[31:0], 32'd0};

	// pexit_q doubles as "running and pc in range" flag for this item
	logic run_ok;
	assign run_ok = (hs_q == HS_RUN) && (17'(pc_q) < plen_q);

	assign dreq.start = (st_q == ST_EXEC) && e_ok && pexit_q && act_q == OP_DIV;
	assign dreq.a = rd_a_q;
	assign dreq.b = rd_b_q;

	always_ff @(posedge clk) begin
		if (st_q == ST_READ) begin
			pexit_q <= run_ok;
		end
		if (st_q == ST_EXEC) begin
			perr_q <= e_err;
			wa_en_q <= e_wa && e_ok && pexit_q;
			wb_en_q <= e_wb && e_ok && pexit_q;
			lw_en_q <= e_lw && e_ok && pexit_q;
			wa_addr_q <= e_waa; wb_addr_q <= e_wba; wa_data_q <= e_wad; wb_data_q <= e_wbd;
			lw_addr_q <= {fbase_frame, LA_W'(opd_q[LA_W-1:0])};
			sp_new_q <= e_sp; fc_new_q <= e_fc; next_q <= e_next;
			mcnt_q <= 2'd0;
		end
		if (st_q == ST_MUL) begin
			res_q  <= mul_sum;
			mcnt_q <= mcnt_q + 1'b1;
			if (mcnt_q == 2'd2) wa_data_q <= mul_sum;
		end
		if (st_q == ST_DIV && drsp.done) wa_data_q <= drsp.q;
	end

	// commit in WB
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0; sp_q <= '0; fc_q <= SP_W'(1); hs_q <= HS_RUN; err_q <= ER_NONE;
		end else if (st_q == ST_WB && hs_q == HS_RUN) begin
			if (!pexit_q) hs_q <= HS_END;
			else if (perr_q != ER_NONE) begin hs_q <= HS_ERR; err_q <= perr_q; end
			else if (act_q == OP_EXIT) hs_q <= HS_EXIT;
			else begin
				pc_q <= next_q[PC_BITS-1:0];
				sp_q <= sp_new_q; fc_q <= fc_new_q;
				if (next_q >= 33'(plen_q)) hs_q <= HS_END;
			end
		end
	end

	// top of stack after the step, tracked from the write plan
	always_ff @(posedge clk) begin
		if (st_q == ST_WB && hs_q == HS_RUN && pexit_q && perr_q == ER_NONE
		    && act_q != OP_EXIT) begin
			if (wa_en_q && wa_addr_q == SA_W'(sp_new_q - 1'b1)) top_q <= wa_data_q;
			else if (wb_en_q) top_q <= wb_data_q;
			else if (act_q == OP_STORE || act_q == OP_POP || act_q == OP_RET)
				top_q <= rd_a_q;
		end else if (st_q == ST_READ && hs_q == HS_RUN) begin
			top_q <= top_q;
		end
	end

	// rd_a_q for pop/store/ret reads sp-2, the new top: correct.
	assign next_pc     = 16'(pc_q);
	assign halted      = (hs_q != HS_RUN);
	assign stop_cause  = hs_q;
	assign error_code  = err_q;
	assign top_value   = (sp_q != '0) ? top_q : 64'd0;
	assign stack_depth = 7'(sp_q);
	assign frame_depth = 7'(fc_q);

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stack machine execute unit: a predictor mirrors
// the pc, operand stack, locals and halt state, and a scoreboard checks every
// result item field by field against it.
// ----------------------------------------------------------------------------
module tb;
	import smeu_pkg::*;

	typedef struct {
		bit [15:0] pc;
		bit        halted;
		bit [1:0]  cause;
		bit [2:0]  err;
		bit [63:0] top;
		bit [6:0]  sdepth;
		bit [6:0]  fdepth;
	} step_result_t;

	// Predictor of the machine plus the queue of results it has promised.
	class machine_scoreboard;
		bit [16:0] plen;
		bit [6:0]  slim;
		bit [4:0]  nloc;
		bit [15:0] pc;
		bit [63:0] stk [STACK_DEPTH];
		bit [6:0]  sp;
		bit [63:0] locs [STACK_DEPTH*LOCALS_PER_FRAME];
		bit        written [STACK_DEPTH*LOCALS_PER_FRAME];
		bit [6:0]  fc;
		bit [1:0]  hs;
		bit [2:0]  lerr;
		step_result_t pending [$];
		bit        failed;

		function new();
			plen = 0; slim = 64; nloc = 16;
			pc = 0; sp = 0; fc = 1; hs = HS_RUN; lerr = ER_NONE;
			failed = 0;
			foreach (written[i]) written[i] = 0;
		endfunction

		function void set_reg(bit [1:0] idx, bit [16:0] val);
			case (idx)
				CFG_PLEN: plen = val;
				CFG_SLIM: slim = val[6:0];
				CFG_NLOC: nloc = val[4:0];
				default: ;
			endcase
		endfunction

		function int cap();
			return (slim < STACK_DEPTH) ? slim : STACK_DEPTH;
		endfunction

		function int nslots();
			return (nloc < LOCALS_PER_FRAME) ? nloc : LOCALS_PER_FRAME;
		endfunction

		function int frame_base();
			return ((fc - 1) % STACK_DEPTH) * LOCALS_PER_FRAME;
		endfunction

		// signed truncating divide done on magnitudes, so MIN / -1 wraps
		function bit [63:0] quotient(bit [63:0] a, bit [63:0] b);
			bit [63:0] ma, mb, q;
			ma = a[63] ? -a : a;
			mb = b[63] ? -b : b;
			q = ma / mb;
			return (a[63] != b[63]) ? -q : q;
		endfunction

		function void execute(op_t act, bit [63:0] opd);
			bit [63:0] nxt, a, b, r;
			bit [2:0]  e;
			int        fb;
			nxt = {48'd0, pc} + 64'd1;
			e = ER_NONE;
			fb = frame_base();
			case (act)
				OP_PUSH: if (sp >= cap()) e = ER_SOVF;
					else begin stk[sp] = opd; sp++; end
				OP_POP: if (sp == 0) e = ER_SUNF; else sp--;
				OP_SWAP: if (opd >= sp) e = ER_BAD;
					else begin
						a = stk[sp-1];
						stk[sp-1] = stk[sp-1-opd];
						stk[sp-1-opd] = a;
					end
				OP_LOAD: if (opd >= nslots()) e = ER_LIDX;
					else if (sp >= cap()) e = ER_SOVF;
					else begin stk[sp] = locs[fb + opd]; sp++; end
				OP_STORE: if (sp == 0) e = ER_SUNF;
					else if (opd >= nslots()) e = ER_LIDX;
					else begin
						sp--;
						locs[fb + opd] = stk[sp];
						written[fb + opd] = 1;
					end
				OP_EXIT: begin
					hs = HS_EXIT;
					return;
				end
				OP_CALL: if (fc >= cap()) e = ER_FOVF;
					else if (sp >= cap()) e = ER_SOVF;
					else begin
						// fresh frame: its slots count as unwritten again
						for (int i = 0; i < LOCALS_PER_FRAME; i++) begin
							locs[(fc % STACK_DEPTH)*LOCALS_PER_FRAME + i] = 0;
							written[(fc % STACK_DEPTH)*LOCALS_PER_FRAME + i] = 0;
						end
						fc++;
						stk[sp] = nxt; sp++;
						nxt = opd;
					end
				OP_RET: if (fc <= 1) e = ER_FUNF;
					else if (sp == 0) e = ER_SUNF;
					else begin fc--; sp--; nxt = stk[sp]; end
				OP_ADD, OP_SUB, OP_MUL, OP_DIV: if (sp < 2) e = ER_SUNF;
					else begin
						b = stk[sp-1];
						a = stk[sp-2];
						if (act == OP_DIV && b == 0) e = ER_DIVZ;
						else begin
							case (act)
								OP_ADD: r = a + b;
								OP_SUB: r = a - b;
								OP_MUL: r = a * b;
								default: r = quotient(a, b);
							endcase
							stk[sp-2] = r;
							sp--;
						end
					end
				default: e = ER_BAD;
			endcase
			if (e != ER_NONE) begin
				hs = HS_ERR;
				lerr = e;
				return;
			end
			pc = nxt[15:0];
			if (nxt >= {47'd0, plen}) hs = HS_END;
		endfunction

		function void note_input(bit [3:0] act, bit [63:0] opd);
			step_result_t r;
			if (hs == HS_RUN) begin
				if (pc >= plen) hs = HS_END;
				else execute(op_t'(act), opd);
			end
			r.pc = pc;
			r.halted = (hs != HS_RUN);
			r.cause = hs;
			r.err = lerr;
			r.top = (sp != 0) ? stk[(sp-1) % STACK_DEPTH] : 64'd0;
			r.sdepth = sp;
			r.fdepth = fc;
			pending.push_back(r);
		endfunction

		function void check_result(step_result_t got);
			step_result_t w;
			if (pending.size() == 0) begin
				$error("result item with nothing expected");
				failed = 1;
				return;
			end
			w = pending.pop_front();
			if (got.pc !== w.pc) begin
				$error("next_pc: expected %0d, got %0d", w.pc, got.pc); failed = 1;
			end
			if (got.halted !== w.halted) begin
				$error("halted: expected %0d, got %0d", w.halted, got.halted); failed = 1;
			end
			if (got.cause !== w.cause) begin
				$error("stop_cause: expected %0d, got %0d", w.cause, got.cause); failed = 1;
			end
			if (got.err !== w.err) begin
				$error("error_code: expected %0d, got %0d", w.err, got.err); failed = 1;
			end
			if (got.top !== w.top) begin
				$error("top_value: expected %h, got %h", w.top, got.top); failed = 1;
			end
			if (got.sdepth !== w.sdepth) begin
				$error("stack_depth: expected %0d, got %0d", w.sdepth, got.sdepth);
				failed = 1;
			end
			if (got.fdepth !== w.fdepth) begin
				$error("frame_depth: expected %0d, got %0d", w.fdepth, got.fdepth);
				failed = 1;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [16:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [3:0]  action;
	logic signed [63:0] operand;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] next_pc;
	logic        halted;
	logic [1:0]  stop_cause;
	logic [2:0]  error_code;
	logic signed [63:0] top_value;
	logic [6:0]  stack_depth;
	logic [6:0]  frame_depth;

	machine_scoreboard sb = new();
	int idle_pct;   // sender gap chance per item, percent
	int stall_pct;  // receiver stall chance per cycle, percent

	stack_machine_execute_unit dut (.*);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// Hard stop in case the block locks up.
	initial begin
		#10000000;
		$display("tb: FAIL");
		$finish;
	end

	// Receiver: random stall set on the falling edge, results taken on the rising.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall = ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		step_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.pc = next_pc;
			got.halted = halted;
			got.cause = stop_cause;
			got.err = error_code;
			got.top = top_value;
			got.sdepth = stack_depth;
			got.fdepth = frame_depth;
			sb.check_result(got);
		end
	end

	// One item on the input channel; payload held while stalled. Valid drops
	// on the falling edge after acceptance, so an accepted item is never
	// offered again.
	task automatic send_item(op_t act, bit [63:0] opd);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		action = act;
		operand = opd;
		do @(posedge clk); while (in_stall);
		sb.note_input(act, opd);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic write_reg(bit [1:0] idx, bit [16:0] val);
		@(negedge clk);
		in_valid = 1'b0;
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	function automatic bit [63:0] rand64();
		case ($urandom_range(5))
			0: return 64'h7fff_ffff_ffff_ffff;
			1: return 64'h8000_0000_0000_0000;
			2: return {64{1'b1}};
			3: return 64'($signed($urandom_range(20)) - 10);
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	// Pick a legal instruction for the predicted state: nothing that halts,
	// no read of an unwritten local, no jump near the end of the program.
	task automatic send_legal();
		op_t act;
		bit [63:0] opd;
		bit ok;
		int idx, fb;
		ok = 0;
		fb = sb.frame_base();
		while (!ok) begin
			act = op_t'($urandom_range(11));
			ok = 1;
			case (act)
				OP_PUSH: begin
					ok = sb.sp < sb.cap() && $urandom_range(99) < 70 - sb.sp;
					opd = rand64();
				end
				OP_POP: ok = sb.sp > 0;
				OP_SWAP: begin
					ok = sb.sp > 0;
					opd = ok ? $urandom_range(sb.sp - 1) : 0;
				end
				OP_LOAD: begin
					idx = $urandom_range(sb.nslots() - 1);
					ok = sb.sp < sb.cap() && sb.written[fb + idx];
					opd = idx;
				end
				OP_STORE: begin
					ok = sb.sp > 0;
					opd = $urandom_range(sb.nslots() - 1);
				end
				OP_CALL: begin
					ok = sb.fc < sb.cap() && sb.sp < sb.cap();
					opd = $urandom_range(20000);
				end
				// return targets kept low, well inside every program length used
				OP_RET: ok = sb.fc > 1 && sb.sp > 0 && sb.stk[sb.sp-1] < 64'd20000;
				OP_EXIT: ok = 0;
				OP_DIV: ok = sb.sp >= 2 && sb.stk[sb.sp-1] != 0;
				default: ok = sb.sp >= 2;
			endcase
		end
		send_item(act, opd);
	endtask

	initial begin
		int kind;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_PLEN;
		cfg_data = '0;
		in_valid = 1'b0;
		action = OP_PUSH;
		operand = '0;
		idle_pct = 0;
		stall_pct = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes, every legal opcode but exit, MIN / -1, a call frame.
		write_reg(CFG_PLEN, 17'h10000);
		write_reg(CFG_SLIM, 17'd64);
		write_reg(CFG_NLOC, 17'd16);
		send_item(OP_PUSH, 64'h7fff_ffff_ffff_ffff);
		send_item(OP_PUSH, 64'h8000_0000_0000_0000);
		send_item(OP_PUSH, {64{1'b1}});
		send_item(OP_DIV, 0);
		send_item(OP_ADD, 0);
		send_item(OP_PUSH, 7);
		send_item(OP_MUL, 0);
		send_item(OP_PUSH, -3);
		send_item(OP_SUB, 0);
		send_item(OP_PUSH, 5);
		send_item(OP_SWAP, 1);
		send_item(OP_SWAP, 0);
		send_item(OP_STORE, 0);
		send_item(OP_STORE, 15);
		send_item(OP_LOAD, 15);
		send_item(OP_LOAD, 0);
		send_item(OP_CALL, 100);
		send_item(OP_PUSH, 42);
		send_item(OP_STORE, 3);
		send_item(OP_LOAD, 3);
		send_item(OP_POP, 0);
		send_item(OP_RET, 0);
		send_item(OP_POP, 0);
		drain();

		// Random phases: limits and idling change only once the block is empty.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0; end
				1: begin
					idle_pct = 54; stall_pct = 0;
					write_reg(CFG_PLEN, 17'd30000);
					write_reg(CFG_SLIM, 17'd1);
					write_reg(CFG_NLOC, 17'd1);
				end
				2: begin
					idle_pct = 0; stall_pct = 54;
					write_reg(CFG_PLEN, 17'h10000);
					write_reg(CFG_SLIM, 17'd8);
					write_reg(CFG_NLOC, 17'd5);
				end
				default: begin
					idle_pct = 37; stall_pct = 37;
					write_reg(CFG_SLIM, 17'd64);
					write_reg(CFG_NLOC, 17'd16);
				end
			endcase
			repeat (450) send_legal();
			drain();
		end

		// Finish with one way of halting, then items that must be ignored.
		kind = $urandom_range(5);
		case (kind)
			0: send_item(OP_EXIT, 0);
			1: begin
				write_reg(CFG_PLEN, 17'd0);
				send_item(OP_PUSH, 1);
			end
			2: begin
				write_reg(CFG_PLEN, {1'b0, sb.pc} + 17'd1);
				send_item(OP_PUSH, 1);
			end
			3: send_item(op_t'($urandom_range(15, 12)), rand64());
			4: send_item(OP_LOAD, 64'd16 + $urandom_range(1000));
			default: begin
				send_item(OP_PUSH, rand64());
				send_item(OP_PUSH, 0);
				send_item(OP_DIV, 0);
			end
		endcase
		repeat (5) send_item(op_t'($urandom_range(15)), rand64());
		@(negedge clk);
		in_valid = 1'b0;
		drain();
		repeat (100) @(posedge clk);

		if (!sb.failed && sb.pending.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

>>> stack_machine_execute_unit.f
design/smeu_pkg.sv
design/smeu_div.sv
design/stack_machine_execute_unit.sv
tb/tb.sv
